// ===== rtl/rfo_pkg.sv =====
// ----------------------------------------------------------------------------
// rfo_pkg
// Shared constants, codes and pointer helpers for the ring FIFO block.
// ----------------------------------------------------------------------------
package rfo_pkg;

    // Field widths fixed by the item format
    localparam int PTR_W      = 6;
    localparam int FIELD_W    = 32;
    localparam int CNT_W      = 32;
    localparam int ACT_W      = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;
    localparam int MODE_W     = 2;

    typedef logic [PTR_W-1:0] ptr_t;
    typedef logic [PTR_W:0]   span_t;
    typedef logic [CNT_W-1:0] cnt_t;

    // Item actions
    localparam logic [ACT_W-1:0] ACT_PUSH        = 3'd0;
    localparam logic [ACT_W-1:0] ACT_POP         = 3'd1;
    localparam logic [ACT_W-1:0] ACT_PEEK        = 3'd2;
    localparam logic [ACT_W-1:0] ACT_CLEAR       = 3'd3;
    localparam logic [ACT_W-1:0] ACT_RESET_STATS = 3'd4;
    localparam logic [ACT_W-1:0] ACT_QUERY       = 3'd5;

    // Overflow modes; any other code rejects
    localparam logic [MODE_W-1:0] MODE_OVERWRITE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BLOCK     = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ERROR     = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_USABLE = 2'd1;

    localparam ptr_t USABLE_RESET = 6'd63;

    // Advance a ring pointer, wrapping at the ring size
    function automatic ptr_t rfo_inc(input ptr_t p, input span_t n);
        span_t s;
        s = {1'b0, p} + span_t'(1);
        return (s == n) ? '0 : s[PTR_W-1:0];
    endfunction

    // Entries held between read and write pointers
    function automatic ptr_t rfo_held(input ptr_t w, input ptr_t r, input span_t n);
        span_t s;
        if (w >= r)
        begin
            s = {1'b0, w} - {1'b0, r};
        end
        else
        begin
            s = {1'b0, w} + n - {1'b0, r};
        end
        return s[PTR_W-1:0];
    endfunction

endpackage

// ===== rtl/rfo_slot_ram.sv =====
// ----------------------------------------------------------------------------
// rfo_slot_ram
// Slot storage: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rfo_slot_ram #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6,
    parameter int WIDTH  = 32
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/ring_fifo_with_overflow_policy.sv =====
// ----------------------------------------------------------------------------
// ring_fifo_with_overflow_policy
// Ring FIFO with one spare slot, selectable overflow policy and statistics.
// ----------------------------------------------------------------------------
// One item is handled at a time. Push, clear, statistics reset and query load
// their result at acceptance; pop and peek first pass through ST_READ, waiting
// for the registered read port of the slot memory. A result waiting on
// out_stall holds the block, so the next item is taken in the cycle the
// result leaves. The ring uses usable_entries + 1 slots (usable_entries
// clamped to 1 .. min(63, SLOT_COUNT - 1)); writing usable_entries empties the
// queue but keeps the statistics. Slot contents are not reset and there is no
// clearing pass: only entries inside the occupancy are ever read. Counters
// wrap at 32 bits; a push that meets a full queue in block mode counts two
// overflows. The configuration port is always ready and should be written only
// while no item is in flight.
// ----------------------------------------------------------------------------
module ring_fifo_with_overflow_policy #(
    parameter int SLOT_COUNT = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,

    // item input
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [rfo_pkg::ACT_W-1:0]      action,
    input  logic [rfo_pkg::FIELD_W-1:0]    push_data,
    input  logic [rfo_pkg::PTR_W-1:0]      peek_offset,

    // result output
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           ok,
    output logic [rfo_pkg::FIELD_W-1:0]    read_data,
    output logic [rfo_pkg::PTR_W-1:0]      occupancy,
    output logic                           is_empty,
    output logic                           is_full,
    output logic [rfo_pkg::CNT_W-1:0]      writes_done,
    output logic [rfo_pkg::CNT_W-1:0]      reads_done,
    output logic [rfo_pkg::CNT_W-1:0]      overflow_count,
    output logic [rfo_pkg::CNT_W-1:0]      underflow_count,
    output logic [rfo_pkg::PTR_W-1:0]      peak_occupancy,

    // configuration write
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [rfo_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rfo_pkg::CFG_DATA_W-1:0] cfg_data
);

    import rfo_pkg::*;

    localparam int ADDR_W   = $clog2(SLOT_COUNT);
    localparam int EXT_A_W  = ADDR_W + PTR_W;
    localparam int EXT_D_W  = DATA_WIDTH + FIELD_W;
    // Largest usable entry count: bounded by the field and by the memory
    localparam int MAX_USE  = (SLOT_COUNT - 1 < 63) ? SLOT_COUNT - 1 : 63;
    localparam ptr_t MAX_USE_P = MAX_USE[PTR_W-1:0];

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } state_t;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    state_t             state_reg, state_next;
    logic [MODE_W-1:0]  mode_reg;
    ptr_t               usable_reg;
    ptr_t               wptr_reg, wptr_next;
    ptr_t               rptr_reg, rptr_next;
    cnt_t               push_cnt_reg, push_cnt_next;
    cnt_t               pop_cnt_reg, pop_cnt_next;
    cnt_t               ovf_cnt_reg, ovf_cnt_next;
    cnt_t               udf_cnt_reg, udf_cnt_next;
    ptr_t               peak_reg, peak_next;
    logic               pend_ok_reg, pend_ok_next;
    logic               pend_hit_reg, pend_hit_next;

    logic               out_valid_reg, out_valid_next;
    logic               ok_reg, ok_next;
    logic [FIELD_W-1:0] rdata_reg, rdata_next;
    ptr_t               occ_reg, occ_next;
    logic               empty_reg, empty_next;
    logic               full_reg, full_next;
    cnt_t               wr_out_reg, rd_out_reg, ovf_out_reg, udf_out_reg;
    ptr_t               peak_out_reg;

    // ------------------------------------------------------------------
    // Combinational signals
    // ------------------------------------------------------------------
    ptr_t               eff_use;
    span_t              ring_n;
    logic               in_accept;
    logic               out_free;
    logic               load_out;
    logic               cfg_we;

    logic               ram_we;
    logic               ram_re;
    ptr_t               ram_wptr;
    ptr_t               ram_rptr;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [EXT_A_W-1:0] waddr_ext;
    logic [EXT_A_W-1:0] raddr_ext;
    logic [EXT_D_W-1:0] wdata_ext;
    logic [DATA_WIDTH-1:0] ram_wdata;
    logic [DATA_WIDTH-1:0] ram_rdata;
    logic [EXT_D_W-1:0] rdata_ext;

    // Clamp the usable count into the range the ring supports
    always_comb
    begin
        if (usable_reg == '0)
        begin
            eff_use = ptr_t'(1);
        end
        else if (usable_reg > MAX_USE_P)
        begin
            eff_use = MAX_USE_P;
        end
        else
        begin
            eff_use = usable_reg;
        end
    end

    assign ring_n    = {1'b0, eff_use} + span_t'(1);
    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = !((state_reg == ST_IDLE) && out_free);
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    // ------------------------------------------------------------------
    // Item processing: pointers and statistics update at acceptance. A
    // pop or peek issues its memory read here and finishes in ST_READ.
    // A push writes the slot at acceptance, so any later read of that
    // slot already sees it; no forwarding is needed.
    // ------------------------------------------------------------------
    always_comb
    begin
        ptr_t  nxt_w;
        ptr_t  occ_push;
        span_t peek_sum;
        logic  store;

        state_next    = state_reg;
        wptr_next     = wptr_reg;
        rptr_next     = rptr_reg;
        push_cnt_next = push_cnt_reg;
        pop_cnt_next  = pop_cnt_reg;
        ovf_cnt_next  = ovf_cnt_reg;
        udf_cnt_next  = udf_cnt_reg;
        peak_next     = peak_reg;
        pend_ok_next  = pend_ok_reg;
        pend_hit_next = pend_hit_reg;
        ok_next       = 1'b1;
        ram_we        = 1'b0;
        ram_re        = 1'b0;
        ram_wptr      = wptr_reg;
        ram_rptr      = rptr_reg;
        load_out      = 1'b0;
        nxt_w         = rfo_inc(wptr_reg, ring_n);
        occ_push      = '0;
        store         = 1'b0;
        peek_sum      = {1'b0, rptr_reg} + {1'b0, peek_offset};

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    case (action)
                        ACT_PUSH:
                        begin
                            store = 1'b1;
                            if (nxt_w == rptr_reg)
                            begin
                                ovf_cnt_next = ovf_cnt_reg + cnt_t'(1);
                                if (mode_reg == MODE_OVERWRITE)
                                begin
                                    // drop the oldest entry
                                    rptr_next = rfo_inc(rptr_reg, ring_n);
                                end
                                else
                                begin
                                    if (mode_reg == MODE_BLOCK)
                                    begin
                                        ovf_cnt_next = ovf_cnt_reg + cnt_t'(2);
                                    end
                                    store   = 1'b0;
                                    ok_next = 1'b0;
                                end
                            end
                            if (store)
                            begin
                                ram_we        = 1'b1;
                                wptr_next     = nxt_w;
                                push_cnt_next = push_cnt_reg + cnt_t'(1);
                                occ_push      = rfo_held(nxt_w, rptr_next, ring_n);
                                if (occ_push > peak_reg)
                                begin
                                    peak_next = occ_push;
                                end
                            end
                            load_out = 1'b1;
                        end
                        ACT_POP:
                        begin
                            if (rptr_reg == wptr_reg)
                            begin
                                udf_cnt_next  = udf_cnt_reg + cnt_t'(1);
                                pend_ok_next  = 1'b0;
                                pend_hit_next = 1'b0;
                            end
                            else
                            begin
                                ram_re        = 1'b1;
                                rptr_next     = rfo_inc(rptr_reg, ring_n);
                                pop_cnt_next  = pop_cnt_reg + cnt_t'(1);
                                pend_ok_next  = 1'b1;
                                pend_hit_next = 1'b1;
                            end
                            state_next = ST_READ;
                        end
                        ACT_PEEK:
                        begin
                            if (peek_offset >= rfo_held(wptr_reg, rptr_reg, ring_n))
                            begin
                                pend_ok_next  = 1'b0;
                                pend_hit_next = 1'b0;
                            end
                            else
                            begin
                                // offset is below occupancy, so one wrap suffices
                                if (peek_sum >= ring_n)
                                begin
                                    peek_sum = peek_sum - ring_n;
                                end
                                ram_re        = 1'b1;
                                ram_rptr      = peek_sum[PTR_W-1:0];
                                pend_ok_next  = 1'b1;
                                pend_hit_next = 1'b1;
                            end
                            state_next = ST_READ;
                        end
                        ACT_CLEAR:
                        begin
                            wptr_next = '0;
                            rptr_next = '0;
                            load_out  = 1'b1;
                        end
                        ACT_RESET_STATS:
                        begin
                            push_cnt_next = '0;
                            pop_cnt_next  = '0;
                            ovf_cnt_next  = '0;
                            udf_cnt_next  = '0;
                            peak_next     = '0;
                            load_out      = 1'b1;
                        end
                        default:
                        begin
                            // query and unused codes only report
                            load_out = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                // hold the read data until the output register is free
                ok_next = pend_ok_reg;
                if (out_free)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // a write of usable_entries empties the queue
        if (cfg_we && (cfg_index == CFG_USABLE))
        begin
            wptr_next = '0;
            rptr_next = '0;
        end
    end

    // ------------------------------------------------------------------
    // Result fields, taken from the state after the action
    // ------------------------------------------------------------------
    assign rdata_ext = {{FIELD_W{1'b0}}, ram_rdata};

    always_comb
    begin
        occ_next   = rfo_held(wptr_next, rptr_next, ring_n);
        empty_next = (occ_next == '0);
        full_next  = (occ_next == eff_use);
        if ((state_reg == ST_READ) && pend_hit_reg)
        begin
            rdata_next = rdata_ext[FIELD_W-1:0];
        end
        else
        begin
            rdata_next = '0;
        end
        out_valid_next = load_out || (out_valid_reg && out_stall);
    end

    // ------------------------------------------------------------------
    // Slot memory
    // ------------------------------------------------------------------
    assign waddr_ext = {{ADDR_W{1'b0}}, ram_wptr};
    assign raddr_ext = {{ADDR_W{1'b0}}, ram_rptr};
    assign ram_waddr = waddr_ext[ADDR_W-1:0];
    assign ram_raddr = raddr_ext[ADDR_W-1:0];
    assign wdata_ext = {{DATA_WIDTH{1'b0}}, push_data};
    assign ram_wdata = wdata_ext[DATA_WIDTH-1:0];

    rfo_slot_ram #(
        .DEPTH  (SLOT_COUNT),
        .ADDR_W (ADDR_W),
        .WIDTH  (DATA_WIDTH)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // State, queue pointers, statistics and registered outputs
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= MODE_OVERWRITE;
            usable_reg    <= USABLE_RESET;
            wptr_reg      <= '0;
            rptr_reg      <= '0;
            push_cnt_reg  <= '0;
            pop_cnt_reg   <= '0;
            ovf_cnt_reg   <= '0;
            udf_cnt_reg   <= '0;
            peak_reg      <= '0;
            pend_ok_reg   <= 1'b0;
            pend_hit_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wptr_reg      <= wptr_next;
            rptr_reg      <= rptr_next;
            push_cnt_reg  <= push_cnt_next;
            pop_cnt_reg   <= pop_cnt_next;
            ovf_cnt_reg   <= ovf_cnt_next;
            udf_cnt_reg   <= udf_cnt_next;
            peak_reg      <= peak_next;
            pend_ok_reg   <= pend_ok_next;
            pend_hit_reg  <= pend_hit_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we && (cfg_index == CFG_MODE))
            begin
                mode_reg <= cfg_data[MODE_W-1:0];
            end
            if (cfg_we && (cfg_index == CFG_USABLE))
            begin
                usable_reg <= cfg_data[PTR_W-1:0];
            end
        end
    end

    // Result payload: load with the item, hold while stalled
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            ok_reg       <= ok_next;
            rdata_reg    <= rdata_next;
            occ_reg      <= occ_next;
            empty_reg    <= empty_next;
            full_reg     <= full_next;
            wr_out_reg   <= push_cnt_next;
            rd_out_reg   <= pop_cnt_next;
            ovf_out_reg  <= ovf_cnt_next;
            udf_out_reg  <= udf_cnt_next;
            peak_out_reg <= peak_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign ok              = ok_reg;
    assign read_data       = rdata_reg;
    assign occupancy       = occ_reg;
    assign is_empty        = empty_reg;
    assign is_full         = full_reg;
    assign writes_done     = wr_out_reg;
    assign reads_done      = rd_out_reg;
    assign overflow_count  = ovf_out_reg;
    assign underflow_count = udf_out_reg;
    assign peak_occupancy  = peak_out_reg;

endmodule

// ===== rtl/rfo_checker.sv =====
// ----------------------------------------------------------------------------
// rfo_checker
// Port-level checks for the ring FIFO, bound to the top level.
// ----------------------------------------------------------------------------
module rfo_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           out_valid,
    input logic                           out_stall,
    input logic                           ok,
    input logic [rfo_pkg::FIELD_W-1:0]    read_data,
    input logic [rfo_pkg::PTR_W-1:0]      occupancy,
    input logic                           is_empty,
    input logic                           is_full,
    input logic [rfo_pkg::CNT_W-1:0]      writes_done
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(read_data)
            && $stable(occupancy) && $stable(writes_done))
        else $error("stalled result changed");

    // Empty flag tracks occupancy
    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (is_empty == (occupancy == '0)))
        else $error("is_empty disagrees with occupancy");

    // A failed action returns no data
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !ok |-> (read_data == '0))
        else $error("failed action returned data");

    // At least one usable entry: full and empty never coincide
    a_full_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_full |-> !is_empty)
        else $error("full and empty together");

endmodule

bind ring_fifo_with_overflow_policy rfo_checker u_rfo_checker (.*);

// ===== tb/ring_fifo_with_overflow_policy_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ring_fifo_with_overflow_policy_tb
// Self-checking bench for the ring FIFO with overflow policy: a status
// tracker mirrors queue contents, pointers and statistics, predicts every
// result and checks the block's results in order under random idling.
// ----------------------------------------------------------------------------
module ring_fifo_with_overflow_policy_tb;

    import rfo_pkg::*;

    // Action and mode codes the package leaves unnamed; they act as query
    // and as reject respectively.
    localparam logic [ACT_W-1:0]  ACT_SPARE_LO = 3'd6;
    localparam logic [ACT_W-1:0]  ACT_SPARE_HI = 3'd7;
    localparam logic [MODE_W-1:0] MODE_SPARE   = 2'd3;

    localparam int CYCLE_LIMIT    = 400000;

    // One result as the block reports it
    typedef struct {
        logic                ok;
        logic [FIELD_W-1:0]  read_data;
        logic [PTR_W-1:0]    occupancy;
        logic                is_empty;
        logic                is_full;
        logic [CNT_W-1:0]    writes_done;
        logic [CNT_W-1:0]    reads_done;
        logic [CNT_W-1:0]    overflow_count;
        logic [CNT_W-1:0]    underflow_count;
        logic [PTR_W-1:0]    peak_occupancy;
    } fifo_status_t;

    // ------------------------------------------------------------------------
    // Status tracker: own copy of the ring, pointers, statistics and
    // configuration; holds the results still due from the block.
    // ------------------------------------------------------------------------
    class fifo_status_tracker;
        logic [FIELD_W-1:0] slots [64];
        int unsigned        wr_ptr;
        int unsigned        rd_ptr;
        logic [CNT_W-1:0]   push_cnt;
        logic [CNT_W-1:0]   pop_cnt;
        logic [CNT_W-1:0]   ovf_cnt;
        logic [CNT_W-1:0]   unf_cnt;
        int unsigned        peak;
        logic [MODE_W-1:0]  mode;
        logic [5:0]         usable;
        fifo_status_t       status_due [$];
        int                 errors;

        function new();
            wr_ptr   = 0;
            rd_ptr   = 0;
            push_cnt = '0;
            pop_cnt  = '0;
            ovf_cnt  = '0;
            unf_cnt  = '0;
            peak     = 0;
            mode     = MODE_OVERWRITE;
            usable   = USABLE_RESET;
            errors   = 0;
        endfunction

        // Zero usable entries means one; six bits cannot exceed 63
        function int unsigned capacity();
            return (usable == 0) ? 1 : usable;
        endfunction

        function int unsigned held();
            int unsigned n;
            n = capacity() + 1;
            if (wr_ptr >= rd_ptr)
            begin
                return wr_ptr - rd_ptr;
            end
            return n - rd_ptr + wr_ptr;
        endfunction

        function int pending();
            return status_due.size();
        endfunction

        function void write_reg(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_MODE)
            begin
                mode = data[MODE_W-1:0];
            end
            else if (idx == CFG_USABLE)
            begin
                usable = data;
                wr_ptr = 0;
                rd_ptr = 0;
            end
        endfunction

        // Apply one accepted item and queue the status it must produce
        function void note_item(input logic [ACT_W-1:0] act,
                                input logic [FIELD_W-1:0] data,
                                input logic [PTR_W-1:0] offset);
            fifo_status_t s;
            int unsigned  n;
            int unsigned  nxt;
            int unsigned  occ;
            bit           store;
            n           = capacity() + 1;
            s.ok        = 1'b1;
            s.read_data = '0;
            case (act)
                ACT_PUSH:
                begin
                    nxt   = (wr_ptr + 1) % n;
                    store = 1'b1;
                    if (nxt == rd_ptr)
                    begin
                        ovf_cnt = ovf_cnt + 1;
                        if (mode == MODE_OVERWRITE)
                        begin
                            rd_ptr = (rd_ptr + 1) % n;
                        end
                        else
                        begin
                            // block mode times out at once and counts twice
                            if (mode == MODE_BLOCK)
                            begin
                                ovf_cnt = ovf_cnt + 1;
                            end
                            store = 1'b0;
                            s.ok  = 1'b0;
                        end
                    end
                    if (store)
                    begin
                        slots[wr_ptr] = data;
                        wr_ptr        = nxt;
                        push_cnt      = push_cnt + 1;
                        if (held() > peak)
                        begin
                            peak = held();
                        end
                    end
                end
                ACT_POP:
                begin
                    if (rd_ptr == wr_ptr)
                    begin
                        unf_cnt = unf_cnt + 1;
                        s.ok    = 1'b0;
                    end
                    else
                    begin
                        s.read_data = slots[rd_ptr];
                        rd_ptr      = (rd_ptr + 1) % n;
                        pop_cnt     = pop_cnt + 1;
                    end
                end
                ACT_PEEK:
                begin
                    if (offset >= held())
                    begin
                        s.ok = 1'b0;
                    end
                    else
                    begin
                        s.read_data = slots[(rd_ptr + offset) % n];
                    end
                end
                ACT_CLEAR:
                begin
                    wr_ptr = 0;
                    rd_ptr = 0;
                end
                ACT_RESET_STATS:
                begin
                    push_cnt = '0;
                    pop_cnt  = '0;
                    ovf_cnt  = '0;
                    unf_cnt  = '0;
                    peak     = 0;
                end
                default:
                begin
                end
            endcase
            occ               = held();
            s.occupancy       = occ[PTR_W-1:0];
            s.is_empty        = (occ == 0);
            s.is_full         = (occ == capacity());
            s.writes_done     = push_cnt;
            s.reads_done      = pop_cnt;
            s.overflow_count  = ovf_cnt;
            s.underflow_count = unf_cnt;
            s.peak_occupancy  = peak[PTR_W-1:0];
            status_due.push_back(s);
        endfunction

        function void report(input string field, input logic [CNT_W-1:0] exp_v,
                             input logic [CNT_W-1:0] act_v);
            if (exp_v !== act_v)
            begin
                errors = errors + 1;
                $display("%0t ns: %s mismatch, expected %h, got %h",
                         $time, field, exp_v, act_v);
            end
        endfunction

        // Compare one accepted result against the oldest status due
        function void check_status(input fifo_status_t got);
            fifo_status_t want;
            if (status_due.size() == 0)
            begin
                errors = errors + 1;
                $display("%0t ns: result with no item outstanding", $time);
                return;
            end
            want = status_due.pop_front();
            report("ok",              CNT_W'(want.ok),             CNT_W'(got.ok));
            report("read_data",       want.read_data,              got.read_data);
            report("occupancy",       CNT_W'(want.occupancy),      CNT_W'(got.occupancy));
            report("is_empty",        CNT_W'(want.is_empty),       CNT_W'(got.is_empty));
            report("is_full",         CNT_W'(want.is_full),        CNT_W'(got.is_full));
            report("writes_done",     want.writes_done,            got.writes_done);
            report("reads_done",      want.reads_done,             got.reads_done);
            report("overflow_count",  want.overflow_count,         got.overflow_count);
            report("underflow_count", want.underflow_count,        got.underflow_count);
            report("peak_occupancy",  CNT_W'(want.peak_occupancy),
                   CNT_W'(got.peak_occupancy));
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Block ports; every input starts at a known value
    // ------------------------------------------------------------------------
    logic                  clk;
    logic                  rst_n       = 1'b0;
    logic                  in_valid    = 1'b0;
    logic                  in_stall;
    logic [ACT_W-1:0]      action      = ACT_QUERY;
    logic [FIELD_W-1:0]    push_data   = '0;
    logic [PTR_W-1:0]      peek_offset = '0;
    logic                  out_valid;
    logic                  out_stall   = 1'b0;
    logic                  ok;
    logic [FIELD_W-1:0]    read_data;
    logic [PTR_W-1:0]      occupancy;
    logic                  is_empty;
    logic                  is_full;
    logic [CNT_W-1:0]      writes_done;
    logic [CNT_W-1:0]      reads_done;
    logic [CNT_W-1:0]      overflow_count;
    logic [CNT_W-1:0]      underflow_count;
    logic [PTR_W-1:0]      peak_occupancy;
    logic                  cfg_valid   = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index   = CFG_MODE;
    logic [CFG_DATA_W-1:0] cfg_data    = '0;

    // Idling rates in percent and the long receiver hold-off
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    logic long_hold = 1'b0;
    int   cycle_count = 0;

    fifo_status_tracker tracker = new();

    ring_fifo_with_overflow_policy dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .action          (action),
        .push_data       (push_data),
        .peek_offset     (peek_offset),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .ok              (ok),
        .read_data       (read_data),
        .occupancy       (occupancy),
        .is_empty        (is_empty),
        .is_full         (is_full),
        .writes_done     (writes_done),
        .reads_done      (reads_done),
        .overflow_count  (overflow_count),
        .underflow_count (underflow_count),
        .peak_occupancy  (peak_occupancy),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Hard stop in case the block hangs or drops a result
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Result side: check what is taken at this edge, then pick the stall for
    // the next one. Values read here are the ones the edge sampled.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        fifo_status_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got.ok              = ok;
            got.read_data       = read_data;
            got.occupancy       = occupancy;
            got.is_empty        = is_empty;
            got.is_full         = is_full;
            got.writes_done     = writes_done;
            got.reads_done      = reads_done;
            got.overflow_count  = overflow_count;
            got.underflow_count = underflow_count;
            got.peak_occupancy  = peak_occupancy;
            tracker.check_status(got);
        end
        out_stall <= long_hold || ($urandom_range(99) < recv_stall_pct);
    end

    // ------------------------------------------------------------------------
    // Item side
    // ------------------------------------------------------------------------

    // Offer one item and hold it until accepted. Valid is left high so a
    // following item can go out back to back; drain_block lowers it.
    task automatic send_item(input logic [ACT_W-1:0] act,
                             input logic [FIELD_W-1:0] data,
                             input logic [PTR_W-1:0] offset);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        action      <= act;
        push_data   <= data;
        peek_offset <= offset;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        tracker.note_item(act, data, offset);
    endtask

    // Stop offering, wait for every result, then let the pipeline settle
    task automatic drain_block();
        in_valid <= 1'b0;
        while (tracker.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    // Write the overflow mode and, optionally, the usable entry count.
    // Upper data bits of the mode write are junk the block must mask.
    task automatic configure(input logic [MODE_W-1:0] mode, input bit set_usable,
                             input logic [5:0] usable);
        logic [CFG_DATA_W-1:0] mode_word;
        mode_word = {4'($urandom_range(15)), mode};
        cfg_valid <= 1'b1;
        cfg_index <= CFG_MODE;
        cfg_data  <= mode_word;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        tracker.write_reg(CFG_MODE, mode_word);
        if (set_usable)
        begin
            cfg_index <= CFG_USABLE;
            cfg_data  <= usable;
            @(posedge clk);
            while (!cfg_ready)
            begin
                @(posedge clk);
            end
            tracker.write_reg(CFG_USABLE, usable);
        end
        cfg_valid <= 1'b0;
    endtask

    // Random item, mostly pushes and pops so the queue fills and drains
    task automatic random_item(input int push_pct);
        logic [ACT_W-1:0]   act;
        logic [FIELD_W-1:0] data;
        logic [PTR_W-1:0]   offset;
        int                 pick;
        data = $urandom();
        pick = $urandom_range(7);
        if (pick == 0)
        begin
            data = '0;
        end
        else if (pick == 1)
        begin
            data = '1;
        end
        // peek offsets cluster around the current occupancy edge
        pick = $urandom_range(2);
        if (pick == 0)
        begin
            offset = PTR_W'($urandom_range(3));
        end
        else if (pick == 1)
        begin
            offset = PTR_W'($urandom_range(tracker.held() + 1));
        end
        else
        begin
            offset = PTR_W'($urandom_range(63));
        end
        if ($urandom_range(99) < push_pct)
        begin
            act = ACT_PUSH;
        end
        else
        begin
            pick = $urandom_range(99);
            if (pick < 70)
            begin
                act = ACT_POP;
            end
            else if (pick < 86)
            begin
                act = ACT_PEEK;
            end
            else if (pick < 91)
            begin
                act = ACT_CLEAR;
            end
            else if (pick < 94)
            begin
                act = ACT_RESET_STATS;
            end
            else
            begin
                act = ACT_W'($urandom_range(ACT_QUERY, ACT_SPARE_HI));
            end
        end
        send_item(act, data, offset);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        logic [5:0]        usable_plan [8];
        logic [MODE_W-1:0] mode_pick;
        int                push_pct;
        usable_plan = '{6'd3, 6'd63, 6'd1, 6'd0, 6'd7, 6'd16, 6'd2, 6'd63};

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset defaults: overwrite mode, 63 usable entries
        send_item(ACT_QUERY, '0, '0);
        send_item(ACT_POP, '0, '0);             // underflow on empty
        send_item(ACT_PEEK, '0, '0);            // peek on empty fails
        send_item(ACT_PUSH, 32'h0000_0000, '0);
        send_item(ACT_PUSH, 32'hFFFF_FFFF, '0);
        send_item(ACT_PEEK, '0, 6'd1);
        send_item(ACT_PEEK, '0, 6'd63);         // past occupancy
        send_item(ACT_POP, '0, '0);
        send_item(ACT_POP, '0, '0);
        send_item(ACT_POP, '0, '0);
        drain_block();

        // Overwrite the oldest entry of a two-entry ring
        configure(MODE_OVERWRITE, 1'b1, 6'd2);
        send_item(ACT_PUSH, 32'hA5A5_0001, '0);
        send_item(ACT_PUSH, 32'hA5A5_0002, '0);
        send_item(ACT_PUSH, 32'hA5A5_0003, '0);
        send_item(ACT_PEEK, '0, '0);
        send_item(ACT_POP, '0, '0);
        drain_block();

        // Block mode on a one-entry ring: rejected and counted twice
        configure(MODE_BLOCK, 1'b1, 6'd1);
        send_item(ACT_PUSH, 32'h1234_5678, '0);
        send_item(ACT_PUSH, 32'h8765_4321, '0);
        send_item(ACT_POP, '0, '0);
        drain_block();

        // Error mode, zero usable entries acts as one
        configure(MODE_ERROR, 1'b1, 6'd0);
        send_item(ACT_PUSH, 32'h0F0F_0F0F, '0);
        send_item(ACT_PUSH, 32'hF0F0_F0F0, '0);
        drain_block();

        // Spare mode rejects; clear, stats reset and the spare actions
        configure(MODE_SPARE, 1'b0, '0);
        send_item(ACT_PUSH, 32'h5555_AAAA, '0);
        send_item(ACT_CLEAR, '0, '0);
        send_item(ACT_RESET_STATS, '0, '0);
        send_item(ACT_SPARE_LO, '0, '0);
        send_item(ACT_SPARE_HI, '0, '0);
        drain_block();

        // Pressure: hold the result side off while items keep coming
        configure(MODE_ERROR, 1'b1, 6'd6);
        fork
            begin
                long_hold <= 1'b1;
                repeat (300) @(posedge clk);
                long_hold <= 1'b0;
            end
            begin
                repeat (40) random_item(60);
            end
        join
        drain_block();

        // Random segments, cycling through the idling profiles
        for (int seg = 0; seg < 8; seg++)
        begin
            case (seg % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 65;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 65;
                end
                default:
                begin
                    send_idle_pct  = 13;
                    recv_stall_pct = 13;
                end
            endcase
            mode_pick = MODE_W'((seg + seg / 4) % 4);
            // odd segments sometimes keep the queue contents across the change
            configure(mode_pick, (seg % 2 == 0) || ($urandom_range(1) == 1),
                      usable_plan[seg]);
            push_pct = (tracker.capacity() > 8) ? 75 : $urandom_range(35, 65);
            repeat (100) random_item(push_pct);
            drain_block();
        end

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (10) @(posedge clk);
        if (tracker.errors == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
